// ===== rtl/bejs_pkg.sv =====
`default_nettype none
package bejs_pkg;

    // Scheduler sizing
    localparam int NUM_QUEUES  = 2;
    localparam int QUEUE_DEPTH = 48;
    localparam int NUM_BANDS   = 16;
    localparam int TOTAL_SLOTS = NUM_QUEUES * QUEUE_DEPTH;

    // Derived widths
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int OFW  = $clog2(NUM_QUEUES + 1);
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int AW   = $clog2(TOTAL_SLOTS);
    localparam int BIW  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int BW   = 4;
    localparam int TW   = 8;
    localparam int INFW = BW + 1;

    // Operation codes
    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_DSP   = 2'd1;
    localparam logic [1:0] OP_CMP   = 2'd2;
    localparam logic [1:0] OP_ABORT = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ENQ_CHECK,
        S_ENQ_SCAN,
        S_ENQ_WRITE,
        S_DSP_QUEUE,
        S_DSP_ORD,
        S_DSP_INFO,
        S_DSP_CHK,
        S_DSP_MOVE_RD,
        S_DSP_MOVE_WR,
        S_CMP_CHECK,
        S_CMP_ORD,
        S_CMP_CHK,
        S_CMP_FREE,
        S_ABT_QUEUE,
        S_ABT_ORD,
        S_ABT_CHK,
        S_OUT
    } t_state;

    typedef logic [QW-1:0] t_qtab [16];
    typedef logic [BW-1:0] t_btab [16];

    function automatic t_qtab queue_table();
        t_qtab t;
        for (int i = 0; i < 16; i++) begin
            t[i] = QW'(i % NUM_QUEUES);
        end
        return t;
    endfunction

    function automatic t_btab band_table();
        t_btab t;
        for (int i = 0; i < 16; i++) begin
            t[i] = BW'(i % NUM_BANDS);
        end
        return t;
    endfunction

    localparam t_qtab QUEUE_OF_BAND = queue_table();
    localparam t_btab BAND_WRAP     = band_table();

    // Flat slot address of a queue and a position within it
    function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                                input logic [PW-1:0] p);
        return AW'(32'(q) * QUEUE_DEPTH + 32'(p));
    endfunction

    // Ring pointer step with wrap
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] q);
        return (q == QW'(NUM_QUEUES - 1)) ? '0 : q + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bejs_ram.sv =====
`default_nettype none
module bejs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/band_exclusive_job_scheduler_top.sv =====
`default_nettype none
// Steps per item: enqueue checks fullness, then scans for the lowest free slot and writes it;
// dispatch visits pending jobs queue by queue and shifts later jobs to close the gap;
// complete searches the queue's pending jobs, then frees the slot; abort releases every
// pending job of every queue. A stalled result side holds the result in S_OUT.
// Throughput: one item at a time; the next item is taken the cycle after the result loads.
// Reset: synchronous active-low i_rst_n clears queues, slot flags, busy marks and counters.
module band_exclusive_job_scheduler_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // opcode[1:0], band[5:2], reset_job[6], queue_sel[8:7], slot_sel[14:9], zero[15]
    input  wire logic [15:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // status[1:0], queue_index[3:2], slot_index[9:4], granted_band[13:10],
    // granted_reset[14], pending_total[22:15], discarded[30:23], zero[31]
    output logic      [31:0] o_m_tdata
);

    localparam int NQ = bejs_pkg::NUM_QUEUES;
    localparam int NB = bejs_pkg::NUM_BANDS;
    localparam int TS = bejs_pkg::TOTAL_SLOTS;
    localparam int QW = bejs_pkg::QW;
    localparam int OFW = bejs_pkg::OFW;
    localparam int PW = bejs_pkg::PW;
    localparam int CW = bejs_pkg::CW;
    localparam int AW = bejs_pkg::AW;
    localparam int BW = bejs_pkg::BW;
    localparam int BIW = bejs_pkg::BIW;
    localparam int TW = bejs_pkg::TW;
    localparam int INFW = bejs_pkg::INFW;

    bejs_pkg::t_state r_state, n_state;

    // Captured item
    logic [BW-1:0] r_band, n_band;
    logic          r_rst, n_rst;
    logic [5:0]    r_ssel, n_ssel;

    // Sequencer counters
    logic [QW-1:0]  r_q, n_q;
    logic [OFW-1:0] r_off, n_off;
    logic [CW-1:0]  r_k, n_k;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic [PW-1:0]  r_s, n_s;

    // Queue state
    logic [PW-1:0] r_head [NQ];
    logic [PW-1:0] n_head [NQ];
    logic [PW-1:0] r_tail [NQ];
    logic [PW-1:0] n_tail [NQ];
    logic [CW-1:0] r_cnt [NQ];
    logic [CW-1:0] n_cnt [NQ];
    logic [CW-1:0] r_used [NQ];
    logic [CW-1:0] n_used [NQ];
    logic [TS-1:0] r_slot_used, n_slot_used;
    logic [NB-1:0] r_busy, n_busy;
    logic [QW-1:0] r_next_q, n_next_q;
    logic [TW-1:0] r_pend, n_pend;

    // Result under construction
    logic [1:0]    r_status, n_status;
    logic [QW-1:0] r_res_q, n_res_q;
    logic [PW-1:0] r_res_s, n_res_s;
    logic [BW-1:0] r_res_band, n_res_band;
    logic          r_res_rst, n_res_rst;
    logic [TW-1:0] r_drop, n_drop;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;

    // RAM ports
    logic            ord_we;
    logic [AW-1:0]   ord_waddr, ord_raddr;
    logic [PW-1:0]   ord_wdata, ord_rdata;
    logic            inf_we;
    logic [AW-1:0]   inf_waddr, inf_raddr;
    logic [INFW-1:0] inf_wdata, inf_rdata;

    logic [PW-1:0] cur_head, cur_tail;
    logic [CW-1:0] cur_cnt, cur_used;
    logic [BW-1:0] inf_band;
    logic          s_accept;

    assign cur_head = r_head[r_q];
    assign cur_tail = r_tail[r_q];
    assign cur_cnt  = r_cnt[r_q];
    assign cur_used = r_used[r_q];
    assign inf_band = inf_rdata[BW-1:0];

    assign o_s_tready = (r_state == bejs_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Pending slot order per queue
    bejs_ram #(.WIDTH(PW), .DEPTH(TS)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // Job band and reset flag per slot
    bejs_ram #(.WIDTH(INFW), .DEPTH(TS)) u_info (
        .i_clk   (i_clk),
        .i_we    (inf_we),
        .i_waddr (inf_waddr),
        .i_wdata (inf_wdata),
        .i_raddr (inf_raddr),
        .o_rdata (inf_rdata)
    );

    // Sequencer: next state and datapath
    always_comb begin
        logic [BW-1:0] wb;
        wb = bejs_pkg::BAND_WRAP[i_s_tdata[5:2]];

        n_state = r_state;
        n_band = r_band;
        n_rst = r_rst;
        n_ssel = r_ssel;
        n_q = r_q;
        n_off = r_off;
        n_k = r_k;
        n_ptr = r_ptr;
        n_s = r_s;
        n_head = r_head;
        n_tail = r_tail;
        n_cnt = r_cnt;
        n_used = r_used;
        n_slot_used = r_slot_used;
        n_busy = r_busy;
        n_next_q = r_next_q;
        n_pend = r_pend;
        n_status = r_status;
        n_res_q = r_res_q;
        n_res_s = r_res_s;
        n_res_band = r_res_band;
        n_res_rst = r_res_rst;
        n_drop = r_drop;
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;

        ord_we = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        ord_raddr = '0;
        inf_we = 1'b0;
        inf_waddr = '0;
        inf_wdata = '0;
        inf_raddr = '0;

        // Drop the shown item once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bejs_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_band = wb;
                    n_rst = i_s_tdata[6];
                    n_ssel = i_s_tdata[14:9];
                    n_status = bejs_pkg::ST_OK;
                    n_res_q = '0;
                    n_res_s = '0;
                    n_res_band = '0;
                    n_res_rst = 1'b0;
                    n_drop = '0;
                    n_off = '0;
                    case (i_s_tdata[1:0])
                        bejs_pkg::OP_ENQ: begin
                            n_q = bejs_pkg::QUEUE_OF_BAND[wb];
                            n_res_q = bejs_pkg::QUEUE_OF_BAND[wb];
                            n_state = bejs_pkg::S_ENQ_CHECK;
                        end
                        bejs_pkg::OP_DSP: begin
                            n_q = r_next_q;
                            n_state = bejs_pkg::S_DSP_QUEUE;
                        end
                        bejs_pkg::OP_CMP: begin
                            if ((32'(i_s_tdata[8:7]) >= NQ) ||
                                (32'(i_s_tdata[14:9]) >= bejs_pkg::QUEUE_DEPTH)) begin
                                n_status = bejs_pkg::ST_BAD_FREE;
                                n_state = bejs_pkg::S_OUT;
                            end else begin
                                n_q = QW'(i_s_tdata[8:7]);
                                n_state = bejs_pkg::S_CMP_CHECK;
                            end
                        end
                        default: begin
                            n_q = '0;
                            n_state = bejs_pkg::S_ABT_QUEUE;
                        end
                    endcase
                end
            end

            // Enqueue: refuse when full, else scan for the lowest free slot
            bejs_pkg::S_ENQ_CHECK: begin
                n_s = '0;
                if (cur_used >= CW'(bejs_pkg::QUEUE_DEPTH)) begin
                    n_status = bejs_pkg::ST_FULL;
                    n_state = bejs_pkg::S_OUT;
                end else begin
                    n_state = bejs_pkg::S_ENQ_SCAN;
                end
            end
            bejs_pkg::S_ENQ_SCAN: begin
                if (!r_slot_used[bejs_pkg::slot_addr(r_q, r_s)]) begin
                    n_state = bejs_pkg::S_ENQ_WRITE;
                end else if (r_s == PW'(bejs_pkg::QUEUE_DEPTH - 1)) begin
                    n_status = bejs_pkg::ST_FULL;
                    n_state = bejs_pkg::S_OUT;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            bejs_pkg::S_ENQ_WRITE: begin
                n_slot_used[bejs_pkg::slot_addr(r_q, r_s)] = 1'b1;
                inf_we = 1'b1;
                inf_waddr = bejs_pkg::slot_addr(r_q, r_s);
                inf_wdata = {r_rst, r_band};
                ord_we = 1'b1;
                ord_waddr = bejs_pkg::slot_addr(r_q, cur_tail);
                ord_wdata = r_s;
                n_tail[r_q] = bejs_pkg::ptr_inc(cur_tail);
                n_cnt[r_q] = cur_cnt + 1'b1;
                n_used[r_q] = cur_used + 1'b1;
                n_pend = r_pend + 1'b1;
                n_res_s = r_s;
                n_state = bejs_pkg::S_OUT;
            end

            // Dispatch: walk queues round-robin, oldest job first
            bejs_pkg::S_DSP_QUEUE: begin
                n_k = '0;
                n_ptr = cur_head;
                if (r_off == OFW'(NQ)) begin
                    n_status = bejs_pkg::ST_NONE;
                    n_state = bejs_pkg::S_OUT;
                end else if (cur_cnt == '0) begin
                    n_q = bejs_pkg::q_inc(r_q);
                    n_off = r_off + 1'b1;
                end else begin
                    n_state = bejs_pkg::S_DSP_ORD;
                end
            end
            bejs_pkg::S_DSP_ORD: begin
                ord_raddr = bejs_pkg::slot_addr(r_q, r_ptr);
                n_state = bejs_pkg::S_DSP_INFO;
            end
            bejs_pkg::S_DSP_INFO: begin
                n_s = ord_rdata;
                inf_raddr = bejs_pkg::slot_addr(r_q, ord_rdata);
                n_state = bejs_pkg::S_DSP_CHK;
            end
            bejs_pkg::S_DSP_CHK: begin
                if (!r_busy[inf_band[BIW-1:0]]) begin
                    n_busy[inf_band[BIW-1:0]] = 1'b1;
                    n_res_q = r_q;
                    n_res_s = r_s;
                    n_res_band = inf_band;
                    n_res_rst = inf_rdata[BW];
                    n_cnt[r_q] = cur_cnt - 1'b1;
                    n_pend = r_pend - 1'b1;
                    n_next_q = bejs_pkg::q_inc(r_q);
                    if (r_k == '0) begin
                        n_head[r_q] = bejs_pkg::ptr_inc(cur_head);
                        n_state = bejs_pkg::S_OUT;
                    end else begin
                        n_state = bejs_pkg::S_DSP_MOVE_RD;
                    end
                end else if (r_k + 1'b1 == cur_cnt) begin
                    n_q = bejs_pkg::q_inc(r_q);
                    n_off = r_off + 1'b1;
                    n_state = bejs_pkg::S_DSP_QUEUE;
                end else begin
                    n_k = r_k + 1'b1;
                    n_ptr = bejs_pkg::ptr_inc(r_ptr);
                    n_state = bejs_pkg::S_DSP_ORD;
                end
            end
            // Close the gap left by the granted job
            bejs_pkg::S_DSP_MOVE_RD: begin
                if (r_k >= cur_cnt) begin
                    n_tail[r_q] = bejs_pkg::ptr_dec(cur_tail);
                    n_state = bejs_pkg::S_OUT;
                end else begin
                    ord_raddr = bejs_pkg::slot_addr(r_q, bejs_pkg::ptr_inc(r_ptr));
                    n_state = bejs_pkg::S_DSP_MOVE_WR;
                end
            end
            bejs_pkg::S_DSP_MOVE_WR: begin
                ord_we = 1'b1;
                ord_waddr = bejs_pkg::slot_addr(r_q, r_ptr);
                ord_wdata = ord_rdata;
                n_ptr = bejs_pkg::ptr_inc(r_ptr);
                n_k = r_k + 1'b1;
                n_state = bejs_pkg::S_DSP_MOVE_RD;
            end

            // Complete: slot must be used and not pending
            bejs_pkg::S_CMP_CHECK: begin
                n_k = '0;
                n_ptr = cur_head;
                if (!r_slot_used[bejs_pkg::slot_addr(r_q, r_ssel[PW-1:0])]) begin
                    n_status = bejs_pkg::ST_BAD_FREE;
                    n_state = bejs_pkg::S_OUT;
                end else begin
                    n_state = bejs_pkg::S_CMP_ORD;
                end
            end
            bejs_pkg::S_CMP_ORD: begin
                if (r_k == cur_cnt) begin
                    inf_raddr = bejs_pkg::slot_addr(r_q, r_ssel[PW-1:0]);
                    n_state = bejs_pkg::S_CMP_FREE;
                end else begin
                    ord_raddr = bejs_pkg::slot_addr(r_q, r_ptr);
                    n_state = bejs_pkg::S_CMP_CHK;
                end
            end
            bejs_pkg::S_CMP_CHK: begin
                if (ord_rdata == r_ssel[PW-1:0]) begin
                    n_status = bejs_pkg::ST_BAD_FREE;
                    n_state = bejs_pkg::S_OUT;
                end else begin
                    n_k = r_k + 1'b1;
                    n_ptr = bejs_pkg::ptr_inc(r_ptr);
                    n_state = bejs_pkg::S_CMP_ORD;
                end
            end
            bejs_pkg::S_CMP_FREE: begin
                n_slot_used[bejs_pkg::slot_addr(r_q, r_ssel[PW-1:0])] = 1'b0;
                n_used[r_q] = cur_used - 1'b1;
                n_busy[inf_band[BIW-1:0]] = 1'b0;
                n_state = bejs_pkg::S_OUT;
            end

            // Abort: release every pending slot, queue by queue
            bejs_pkg::S_ABT_QUEUE: begin
                n_k = '0;
                n_ptr = cur_head;
                if (r_off == OFW'(NQ)) begin
                    n_pend = '0;
                    n_state = bejs_pkg::S_OUT;
                end else begin
                    n_state = bejs_pkg::S_ABT_ORD;
                end
            end
            bejs_pkg::S_ABT_ORD: begin
                if (r_k == cur_cnt) begin
                    n_head[r_q] = cur_tail;
                    n_cnt[r_q] = '0;
                    n_q = bejs_pkg::q_inc(r_q);
                    n_off = r_off + 1'b1;
                    n_state = bejs_pkg::S_ABT_QUEUE;
                end else begin
                    ord_raddr = bejs_pkg::slot_addr(r_q, r_ptr);
                    n_state = bejs_pkg::S_ABT_CHK;
                end
            end
            bejs_pkg::S_ABT_CHK: begin
                if (r_slot_used[bejs_pkg::slot_addr(r_q, ord_rdata)]) begin
                    n_slot_used[bejs_pkg::slot_addr(r_q, ord_rdata)] = 1'b0;
                    n_used[r_q] = cur_used - 1'b1;
                end
                n_drop = r_drop + 1'b1;
                n_k = r_k + 1'b1;
                n_ptr = bejs_pkg::ptr_inc(r_ptr);
                n_state = bejs_pkg::S_ABT_ORD;
            end

            // Hand the result to the output register once it is free
            bejs_pkg::S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data = {1'b0, r_drop, r_pend, r_res_rst, r_res_band,
                                  6'(r_res_s), 2'(r_res_q), r_status};
                    n_state = bejs_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bejs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bejs_pkg::S_IDLE;
            r_q <= '0;
            r_off <= '0;
            r_k <= '0;
            r_ptr <= '0;
            r_s <= '0;
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i] <= '0;
                r_used[i] <= '0;
            end
            r_slot_used <= '0;
            r_busy <= '0;
            r_next_q <= '0;
            r_pend <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q <= n_q;
            r_off <= n_off;
            r_k <= n_k;
            r_ptr <= n_ptr;
            r_s <= n_s;
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt <= n_cnt;
            r_used <= n_used;
            r_slot_used <= n_slot_used;
            r_busy <= n_busy;
            r_next_q <= n_next_q;
            r_pend <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_band <= n_band;
        r_rst <= n_rst;
        r_ssel <= n_ssel;
        r_status <= n_status;
        r_res_q <= n_res_q;
        r_res_s <= n_res_s;
        r_res_band <= n_res_band;
        r_res_rst <= n_res_rst;
        r_drop <= n_drop;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("scheduler took a second item while busy");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pend) <= TS)
        else $error("pending total exceeds slot count");

    for (genvar g = 0; g < NQ; g++) begin : g_qchk
        a_cnt_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == bejs_pkg::S_IDLE) |-> (r_cnt[g] <= r_used[g]))
            else $error("more pending jobs than used slots");
        a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            32'(r_used[g]) <= bejs_pkg::QUEUE_DEPTH)
            else $error("used slot count exceeds queue depth");
    end
`endif

endmodule
`default_nettype wire

// ===== test/tb_band_exclusive_job_scheduler_checker.sv =====
`timescale 1ns / 1ps
module tb_band_exclusive_job_scheduler_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // opcode[1:0], band[5:2], reset_job[6], queue_sel[8:7], slot_sel[14:9], zero[15]
    input  wire logic [15:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // status[1:0], queue_index[3:2], slot_index[9:4], granted_band[13:10],
    // granted_reset[14], pending_total[22:15], discarded[30:23], zero[31]
    input  wire logic [31:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_outstanding
);

    typedef struct packed {
        logic       zero;
        logic [7:0] discarded;
        logic [7:0] pending_total;
        logic       granted_reset;
        logic [3:0] granted_band;
        logic [5:0] slot_index;
        logic [1:0] queue_index;
        logic [1:0] status;
    } t_sched_result;

    // Shadow of the scheduler state
    logic [5:0] order_ring [bejs_pkg::NUM_QUEUES][bejs_pkg::QUEUE_DEPTH];
    logic       slot_taken [bejs_pkg::NUM_QUEUES][bejs_pkg::QUEUE_DEPTH];
    logic [3:0] job_band   [bejs_pkg::NUM_QUEUES][bejs_pkg::QUEUE_DEPTH];
    logic       job_reset  [bejs_pkg::NUM_QUEUES][bejs_pkg::QUEUE_DEPTH];
    int         head_ptr [bejs_pkg::NUM_QUEUES];
    int         tail_ptr [bejs_pkg::NUM_QUEUES];
    int         wait_cnt [bejs_pkg::NUM_QUEUES];
    int         occupied [bejs_pkg::NUM_QUEUES];
    logic       busy_band [bejs_pkg::NUM_BANDS];
    int         rr_queue;
    int         waiting_jobs;

    t_sched_result expected_results [$];

    function automatic int ring_at(int q, int k);
        return (head_ptr[q] + k) % bejs_pkg::QUEUE_DEPTH;
    endfunction

    function automatic logic job_waiting(int q, int s);
        for (int k = 0; k < wait_cnt[q]; k++)
            if (order_ring[q][ring_at(q, k)] == s) return 1'b1;
        return 1'b0;
    endfunction

    task automatic clear_schedule();
        for (int q = 0; q < bejs_pkg::NUM_QUEUES; q++) begin
            head_ptr[q] = 0;
            tail_ptr[q] = 0;
            wait_cnt[q] = 0;
            occupied[q] = 0;
            for (int s = 0; s < bejs_pkg::QUEUE_DEPTH; s++) begin
                order_ring[q][s] = '0;
                slot_taken[q][s] = 1'b0;
            end
        end
        for (int b = 0; b < bejs_pkg::NUM_BANDS; b++) busy_band[b] = 1'b0;
        rr_queue = 0;
        waiting_jobs = 0;
    endtask

    // Apply one command to the shadow state and return its result
    function automatic t_sched_result schedule_step(logic [15:0] cmd);
        t_sched_result r;
        logic [1:0] op;
        int band, q, s, fq, fk;
        logic rst_job, found;
        op = cmd[1:0];
        band = int'(cmd[5:2]) % bejs_pkg::NUM_BANDS;
        rst_job = cmd[6];
        r = '0;
        if (op == bejs_pkg::OP_ENQ) begin
            q = band % bejs_pkg::NUM_QUEUES;
            r.queue_index = 2'(q);
            s = bejs_pkg::QUEUE_DEPTH;
            for (int i = bejs_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
                if (!slot_taken[q][i]) s = i;
            if (occupied[q] >= bejs_pkg::QUEUE_DEPTH || s >= bejs_pkg::QUEUE_DEPTH) begin
                r.status = bejs_pkg::ST_FULL;
            end else begin
                slot_taken[q][s] = 1'b1;
                job_band[q][s] = 4'(band);
                job_reset[q][s] = rst_job;
                occupied[q]++;
                order_ring[q][tail_ptr[q]] = 6'(s);
                tail_ptr[q] = (tail_ptr[q] + 1) % bejs_pkg::QUEUE_DEPTH;
                wait_cnt[q]++;
                waiting_jobs++;
                r.slot_index = 6'(s);
            end
        end else if (op == bejs_pkg::OP_DSP) begin
            found = 1'b0;
            fq = 0;
            fk = 0;
            for (int off = 0; off < bejs_pkg::NUM_QUEUES && !found; off++) begin
                q = (rr_queue + off) % bejs_pkg::NUM_QUEUES;
                for (int k = 0; k < wait_cnt[q] && !found; k++) begin
                    s = order_ring[q][ring_at(q, k)];
                    if (!busy_band[job_band[q][s]]) begin
                        found = 1'b1;
                        fq = q;
                        fk = k;
                    end
                end
            end
            if (!found) begin
                r.status = bejs_pkg::ST_NONE;
            end else begin
                q = fq;
                s = order_ring[q][ring_at(q, fk)];
                r.granted_band = job_band[q][s];
                r.granted_reset = job_reset[q][s];
                busy_band[job_band[q][s]] = 1'b1;
                if (fk == 0) begin
                    head_ptr[q] = (head_ptr[q] + 1) % bejs_pkg::QUEUE_DEPTH;
                end else begin
                    for (int k = fk; k + 1 < wait_cnt[q]; k++)
                        order_ring[q][ring_at(q, k)] = order_ring[q][ring_at(q, k + 1)];
                    tail_ptr[q] = (tail_ptr[q] + bejs_pkg::QUEUE_DEPTH - 1)
                                  % bejs_pkg::QUEUE_DEPTH;
                end
                wait_cnt[q]--;
                waiting_jobs--;
                rr_queue = (q + 1) % bejs_pkg::NUM_QUEUES;
                r.queue_index = 2'(q);
                r.slot_index = 6'(s);
            end
        end else if (op == bejs_pkg::OP_CMP) begin
            q = int'(cmd[8:7]);
            s = int'(cmd[14:9]);
            if (q >= bejs_pkg::NUM_QUEUES || s >= bejs_pkg::QUEUE_DEPTH) begin
                r.status = bejs_pkg::ST_BAD_FREE;
            end else if (!slot_taken[q][s] || job_waiting(q, s)) begin
                r.status = bejs_pkg::ST_BAD_FREE;
            end else begin
                slot_taken[q][s] = 1'b0;
                occupied[q]--;
                busy_band[job_band[q][s]] = 1'b0;
            end
        end else begin
            for (q = 0; q < bejs_pkg::NUM_QUEUES; q++) begin
                for (int k = 0; k < wait_cnt[q]; k++) begin
                    s = order_ring[q][ring_at(q, k)];
                    if (slot_taken[q][s]) begin
                        slot_taken[q][s] = 1'b0;
                        occupied[q]--;
                    end
                    r.discarded++;
                end
                head_ptr[q] = tail_ptr[q];
                wait_cnt[q] = 0;
            end
            waiting_jobs = 0;
        end
        r.pending_total = 8'(waiting_jobs);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
        clear_schedule();
    end

    // Predict on each accepted command, compare on each accepted result
    always @(posedge i_clk) begin
        t_sched_result got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                expected_results.insert(expected_results.size(), schedule_step(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", int'(i_m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.queue_index != want.queue_index)
                        report_mismatch("queue_index", got.queue_index, want.queue_index);
                    if (got.slot_index != want.slot_index)
                        report_mismatch("slot_index", got.slot_index, want.slot_index);
                    if (got.granted_band != want.granted_band)
                        report_mismatch("granted_band", got.granted_band, want.granted_band);
                    if (got.granted_reset != want.granted_reset)
                        report_mismatch("granted_reset", got.granted_reset,
                                        want.granted_reset);
                    if (got.pending_total != want.pending_total)
                        report_mismatch("pending_total", got.pending_total,
                                        want.pending_total);
                    if (got.discarded != want.discarded)
                        report_mismatch("discarded", got.discarded, want.discarded);
                    if (got.zero != 1'b0)
                        report_mismatch("pad bit", got.zero, 0);
                end
            end
            o_outstanding = expected_results.size();
        end
    end

endmodule

// ===== test/tb_band_exclusive_job_scheduler_top.sv =====
`timescale 1ns / 1ps
module tb_band_exclusive_job_scheduler_top;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          outstanding;
    int          cycle_count;
    logic        hold_sink;

    band_exclusive_job_scheduler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    tb_band_exclusive_job_scheduler_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Stop a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] pack_cmd(logic [1:0] op, logic [3:0] band,
                                             logic rst_job, logic [1:0] qsel,
                                             logic [5:0] ssel);
        return {1'b0, ssel, qsel, rst_job, band, op};
    endfunction

    // Offer one item after a random gap (none when no_gap is set) and hold it until taken
    task automatic send_item(logic [15:0] cmd, logic no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_random(int mode);
        logic [1:0] op;
        int pick;
        pick = $urandom_range(0, 99);
        op = (pick < 40) ? bejs_pkg::OP_ENQ : (pick < 70) ? bejs_pkg::OP_DSP :
             (pick < 97) ? bejs_pkg::OP_CMP : bejs_pkg::OP_ABORT;
        if (mode == 1 && op == bejs_pkg::OP_ABORT) op = bejs_pkg::OP_ENQ;
        // Completions mostly name a real slot, sometimes anything
        send_item(pack_cmd(op, 4'($urandom), 1'($urandom),
                           ($urandom_range(0, 9) == 0) ? 2'($urandom)
                               : 2'($urandom_range(0, bejs_pkg::NUM_QUEUES - 1)),
                           ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                        : 6'($urandom_range(0, 7))),
                  mode == 2);
    endtask

    // Result side: random stalls, plus one long hold-off
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        hold_sink = 1'b0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty cases, extremes, every operation
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ABORT, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ENQ, 4'd15, 1'b1, 2'd3, 6'd63), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ENQ, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ENQ, 4'd2, 1'b1, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ENQ, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd3, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd1, 6'd63), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd1, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd0, 6'd47), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ABORT, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);

        // Fill queue 1 past full while the result side holds off
        hold_sink = 1'b1;
        for (int i = 0; i < 50; i++)
            send_item(pack_cmd(bejs_pkg::OP_ENQ, 4'(2 * $urandom_range(0, 7) + 1),
                               1'($urandom), 2'd0, 6'd0), 1'b1);
        send_item(pack_cmd(bejs_pkg::OP_DSP, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_CMP, 4'd0, 1'b0, 2'd1, 6'd47), 1'b0);
        send_item(pack_cmd(bejs_pkg::OP_ABORT, 4'd0, 1'b0, 2'd0, 6'd0), 1'b0);
        s_tvalid <= 1'b0;

        // Pause until every result has come back
        while (outstanding != 0) @(posedge i_clk);

        // Random: mostly busy traffic, some phases without aborts, some back to back
        for (int i = 0; i < 400; i++) send_random((i / 100) % 3);
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bejs_pkg.sv
rtl/bejs_ram.sv
rtl/band_exclusive_job_scheduler_top.sv
test/tb_band_exclusive_job_scheduler_checker.sv
test/tb_band_exclusive_job_scheduler_top.sv
